/* hdl/text_buffer_cursor_editor_top_defines.svh */
// assertion macros for the text buffer cursor editor checker
`ifndef TEXT_BUFFER_CURSOR_EDITOR_TOP_DEFINES_SVH
`define TEXT_BUFFER_CURSOR_EDITOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TBCE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbce assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TBCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbce assertion failed");

`endif

/* hdl/tbce_pkg.sv */
// shared types and constants for the text buffer cursor editor
package tbce_pkg;

  localparam int TEXT_DEPTH_DEF = 256;
  localparam int CLIP_DEPTH_DEF = 256;

  localparam int OPCODE_W = 3;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int RIDX_W   = 8;
  localparam int POS_W    = 9;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OVF = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_INSERT = 3'd2,
    OP_CUT    = 3'd3,
    OP_COPY   = 3'd4,
    OP_PASTE  = 3'd5,
    OP_READ   = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_XRD,
    S_XWR,
    S_RDCAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic move_wr;
    logic x_rd;
    logic x_wr;
    logic rd_cap;
    logic emit;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    can_move;
    logic    room_ok;
    logic    n_zero;
    logic    clip_zero;
    logic    ridx_ok;
    logic    k_last;
    logic    out_busy;
  } sts_t;

endpackage

/* hdl/tbce_ram.sv */
// generic single write port ram with registered read
module tbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/tbce_ctrl.sv */
// command sequencer for the text buffer cursor editor
module tbce_ctrl import tbce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          OP_LEFT, OP_RIGHT: state_next = sts.can_move ? S_MOVE : S_DONE;
          OP_CUT, OP_COPY:   state_next = sts.n_zero ? S_DONE : S_XRD;
          OP_PASTE: begin
            state_next = (!sts.room_ok || sts.clip_zero) ? S_DONE : S_XRD;
          end
          OP_READ:           state_next = sts.ridx_ok ? S_RDCAP : S_DONE;
          default:           state_next = S_DONE;
        endcase
      end
      S_MOVE: begin
        cmd.move_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_XRD: begin
        cmd.x_rd   = 1'b1;
        state_next = S_XWR;
      end
      S_XWR: begin
        cmd.x_wr   = 1'b1;
        state_next = sts.k_last ? S_DONE : S_XRD;
      end
      S_RDCAP: begin
        cmd.rd_cap = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hdl/tbce_dp.sv */
// gap buffer datapath: text and clipboard stores, lengths, cursor, result register
module tbce_dp import tbce_pkg::*; #(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
  parameter int CLIP_DEPTH = CLIP_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [CHAR_W-1:0]   char_in,
  input  logic [COUNT_W-1:0]  count,
  input  logic [RIDX_W-1:0]   read_index,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                res_ready,
  output logic                res_valid,
  output logic                status,
  output logic [POS_W-1:0]    cursor_pos,
  output logic [POS_W-1:0]    text_size,
  output logic [POS_W-1:0]    clip_len,
  output logic [CHAR_W-1:0]   read_char,
  output logic                read_valid
);

  localparam int AW  = $clog2(TEXT_DEPTH);
  localparam int LW  = $clog2(TEXT_DEPTH + 1);
  localparam int CAW = $clog2(CLIP_DEPTH);
  localparam int CLW = $clog2(CLIP_DEPTH + 1);
  localparam int M1  = (LW > CLW) ? LW : CLW;
  localparam int M2  = (M1 > POS_W) ? M1 : POS_W;
  localparam int WW  = M2 + 1;

  opcode_t           op;
  logic [CHAR_W-1:0] ch;
  logic [COUNT_W-1:0] cnt;
  logic [RIDX_W-1:0] ridx;
  logic [LW-1:0]     cursor, len;
  logic [CLW-1:0]    clen, n, k;
  logic              ovf, rvalid;
  logic [CHAR_W-1:0] rchar;

  logic [WW-1:0] w_cur, w_len, w_clip, w_k, w_n, w_ridx, w_cnt, w_gap, w_room, w_ncalc;
  logic          ins_ok, paste_ok;

  logic              t_we, c_we;
  logic [AW-1:0]     t_waddr, t_raddr;
  logic [CAW-1:0]    c_waddr, c_raddr;
  logic [CHAR_W-1:0] t_wdata, t_rdata, c_wdata, c_rdata;

  tbce_ram #(.WIDTH(CHAR_W), .DEPTH(TEXT_DEPTH)) u_text (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  tbce_ram #(.WIDTH(CHAR_W), .DEPTH(CLIP_DEPTH)) u_clip (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  assign w_cur    = WW'(cursor);
  assign w_len    = WW'(len);
  assign w_clip   = WW'(clen);
  assign w_k      = WW'(k);
  assign w_n      = WW'(n);
  assign w_ridx   = WW'(ridx);
  assign w_cnt    = WW'(cnt);
  assign w_gap    = WW'(TEXT_DEPTH) - w_len;
  assign w_room   = w_len - w_cur;
  assign ins_ok   = w_len < WW'(TEXT_DEPTH);
  assign paste_ok = (w_len + w_clip) <= WW'(TEXT_DEPTH);

  // span taken by cut or copy
  always_comb begin
    w_ncalc = w_cnt;
    if (w_ncalc > w_room) begin
      w_ncalc = w_room;
    end
    if (w_ncalc > WW'(CLIP_DEPTH)) begin
      w_ncalc = WW'(CLIP_DEPTH);
    end
  end

  always_comb begin
    sts.op        = op;
    sts.can_move  = (op == OP_LEFT) ? (cursor != '0) : (cursor < len);
    sts.room_ok   = (op == OP_PASTE) ? paste_ok : ins_ok;
    sts.n_zero    = (w_ncalc == '0);
    sts.clip_zero = (clen == '0);
    sts.ridx_ok   = (w_ridx < w_len) && (w_ridx < WW'(TEXT_DEPTH));
    sts.k_last    = ((w_k + WW'(1)) == w_n);
    sts.out_busy  = res_valid && !res_ready;
  end

  // store addressing; text after the cursor sits above the gap
  always_comb begin
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_raddr = '0;
    c_we    = 1'b0;
    c_waddr = '0;
    c_wdata = '0;
    c_raddr = '0;
    if (cmd.exec) begin
      case (op)
        OP_LEFT:   t_raddr = AW'(w_cur - WW'(1));
        OP_RIGHT:  t_raddr = AW'(w_cur + w_gap);
        OP_INSERT: begin
          t_we    = ins_ok;
          t_waddr = AW'(w_cur);
          t_wdata = ch;
        end
        OP_READ:   t_raddr = AW'((w_ridx < w_cur) ? w_ridx : (w_ridx + w_gap));
        default:   t_raddr = '0;
      endcase
    end
    if (cmd.move_wr) begin
      t_we    = 1'b1;
      t_wdata = t_rdata;
      t_waddr = (op == OP_LEFT) ? AW'(w_cur - WW'(1) + w_gap) : AW'(w_cur);
    end
    if (cmd.x_rd) begin
      if (op == OP_PASTE) begin
        c_raddr = CAW'(w_k);
      end else begin
        t_raddr = AW'(w_cur + w_gap + w_k);
      end
    end
    if (cmd.x_wr) begin
      if (op == OP_PASTE) begin
        t_we    = 1'b1;
        t_waddr = AW'(w_cur + w_k);
        t_wdata = c_rdata;
      end else begin
        c_we    = 1'b1;
        c_waddr = CAW'(w_k);
        c_wdata = t_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= opcode_t'(opcode);
      ch     <= char_in;
      cnt    <= count;
      ridx   <= read_index;
      ovf    <= ST_OK;
      rchar  <= '0;
      rvalid <= 1'b0;
    end
    if (cmd.exec) begin
      case (op)
        OP_INSERT: begin
          if (!ins_ok) begin
            ovf <= ST_OVF;
          end
        end
        OP_CUT, OP_COPY: begin
          n <= CLW'(w_ncalc);
          k <= '0;
        end
        OP_PASTE: begin
          if (!paste_ok) begin
            ovf <= ST_OVF;
          end
          n <= clen;
          k <= '0;
        end
        default: k <= '0;
      endcase
    end
    if (cmd.x_wr) begin
      k <= CLW'(w_k + WW'(1));
    end
    if (cmd.rd_cap) begin
      rchar  <= t_rdata;
      rvalid <= 1'b1;
    end
    if (cmd.emit) begin
      status     <= ovf;
      cursor_pos <= w_cur[POS_W-1:0];
      text_size  <= w_len[POS_W-1:0];
      clip_len   <= w_clip[POS_W-1:0];
      read_char  <= rchar;
      read_valid <= rvalid;
    end
  end

  // control state: lengths, cursor, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      len       <= '0;
      clen      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (op)
          OP_INSERT: begin
            if (ins_ok) begin
              cursor <= LW'(w_cur + WW'(1));
              len    <= LW'(w_len + WW'(1));
            end
          end
          OP_CUT, OP_COPY: clen <= CLW'(w_ncalc);
          default: clen <= clen;
        endcase
      end
      if (cmd.move_wr) begin
        cursor <= (op == OP_LEFT) ? LW'(w_cur - WW'(1)) : LW'(w_cur + WW'(1));
      end
      if (cmd.x_wr && sts.k_last) begin
        if (op == OP_PASTE) begin
          cursor <= LW'(w_cur + w_n);
          len    <= LW'(w_len + w_n);
        end else if (op == OP_CUT) begin
          len <= LW'(w_len - w_n);
        end
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/text_buffer_cursor_editor_top.sv */
// from accept to result register: insert, read miss and no-op moves pass through exec and done;
// a cursor move adds a move state, a read hit a capture state, and cut, copy or paste of n characters
// adds a read state and a write state per character, using the stores' separate read and write ports;
// a new command word is taken only once the last result has been emitted; a held result adds its stall
// reset (rst, synchronous): cursor, text length and clipboard length cleared, no result held;
// store contents are not cleared and are read only below the lengths
module text_buffer_cursor_editor_top import tbce_pkg::*; #(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
  parameter int CLIP_DEPTH = CLIP_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // command channel
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [CHAR_W-1:0]   char_in,
  input  logic [COUNT_W-1:0]  count,
  input  logic [RIDX_W-1:0]   read_index,
  // result channel
  output logic                res_valid,
  input  logic                res_ready,
  output logic                status,
  output logic [POS_W-1:0]    cursor_pos,
  output logic [POS_W-1:0]    text_size,
  output logic [POS_W-1:0]    clip_len,
  output logic [CHAR_W-1:0]   read_char,
  output logic                read_valid
);

  // sequencer commands and datapath flags
  cmd_t cmd;
  sts_t sts;

  // state machine: one command word at a time
  tbce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // gap buffer: text before the cursor at the bottom of the store,
  // text after it at the top, free room in between
  tbce_dp #(
    .TEXT_DEPTH (TEXT_DEPTH),
    .CLIP_DEPTH (CLIP_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .opcode     (opcode),
    .char_in    (char_in),
    .count      (count),
    .read_index (read_index),
    .cmd        (cmd),
    .sts        (sts),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .status     (status),
    .cursor_pos (cursor_pos),
    .text_size  (text_size),
    .clip_len   (clip_len),
    .read_char  (read_char),
    .read_valid (read_valid)
  );

endmodule

/* hdl/tbce_checker.sv */
// port-level checker for the text buffer cursor editor, bound to the top level
`include "text_buffer_cursor_editor_top_defines.svh"

module tbce_checker import tbce_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic [OPCODE_W-1:0] opcode,
  input logic [CHAR_W-1:0]   char_in,
  input logic [COUNT_W-1:0]  count,
  input logic [RIDX_W-1:0]   read_index,
  input logic                res_valid,
  input logic                res_ready,
  input logic                status,
  input logic [POS_W-1:0]    cursor_pos,
  input logic [POS_W-1:0]    text_size,
  input logic [POS_W-1:0]    clip_len,
  input logic [CHAR_W-1:0]   read_char,
  input logic                read_valid
);

  `TBCE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(cursor_pos))
  `TBCE_ASSERT_NOW(a_cursor_in_text, res_valid, cursor_pos <= text_size)
  `TBCE_ASSERT_NOW(a_char_zero, res_valid && !read_valid, read_char == '0)
  `TBCE_ASSERT_NOW(a_ovf_no_read, res_valid && status, !read_valid)
  `TBCE_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind text_buffer_cursor_editor_top tbce_checker u_tbce_checker (.*);

/* tb/text_buffer_cursor_editor_top_test.sv */
// self-checking testbench for the text buffer cursor editor: random commands against a text model
`timescale 1ns / 100ps

module text_buffer_cursor_editor_top_test;
  import tbce_pkg::*;

  localparam int DEPTH = TEXT_DEPTH_DEF;

  // one command word and one result word
  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [CHAR_W-1:0]   ch;
    logic [COUNT_W-1:0]  cnt;
    logic [RIDX_W-1:0]   ridx;
  } edit_cmd_t;

  typedef struct {
    logic              st;
    logic [POS_W-1:0]  cur;
    logic [POS_W-1:0]  tlen;
    logic [POS_W-1:0]  clen;
    logic [CHAR_W-1:0] rch;
    logic              rvld;
  } edit_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  logic [OPCODE_W-1:0] opcode = '0;
  logic [CHAR_W-1:0]   char_in = '0;
  logic [COUNT_W-1:0]  count = '0;
  logic [RIDX_W-1:0]   read_index = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic status;
  logic [POS_W-1:0] cursor_pos, text_size, clip_len;
  logic [CHAR_W-1:0] read_char;
  logic read_valid;

  always #2 clk = ~clk;

  text_buffer_cursor_editor_top uut (
    .clk, .rst, .cmd_valid, .cmd_ready, .opcode, .char_in, .count, .read_index,
    .res_valid, .res_ready, .status, .cursor_pos, .text_size, .clip_len,
    .read_char, .read_valid
  );

  // shadow copy of the editor contents
  logic [7:0] text_mem [DEPTH];
  logic [7:0] clip_mem [DEPTH];
  int text_n, cur_n, clip_n;

  edit_cmd_t pending_cmds[$];
  edit_res_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int cmds_accepted = 0;

  // knobs set by the stimulus process
  bit idle_enable = 1'b1;
  bit hold_results = 1'b0;

  // apply one command to the shadow copy and return the expected result word
  function automatic edit_res_t apply_edit(edit_cmd_t c);
    edit_res_t r;
    int n;
    r = '{st: ST_OK, cur: 0, tlen: 0, clen: 0, rch: 0, rvld: 0};
    case (c.op)
      OP_LEFT: if (cur_n > 0) cur_n--;
      OP_RIGHT: if (cur_n < text_n) cur_n++;
      OP_INSERT: begin
        if (text_n >= DEPTH) r.st = ST_OVF;
        else begin
          for (int i = text_n; i > cur_n; i--) text_mem[i] = text_mem[i-1];
          text_mem[cur_n] = c.ch;
          text_n++;
          cur_n++;
        end
      end
      OP_CUT, OP_COPY: begin
        n = c.cnt;
        if (n > text_n - cur_n) n = text_n - cur_n;
        if (n > DEPTH) n = DEPTH;
        for (int i = 0; i < n; i++) clip_mem[i] = text_mem[cur_n+i];
        clip_n = n;
        if (c.op == OP_CUT) begin
          for (int i = cur_n; i < text_n - n; i++) text_mem[i] = text_mem[i+n];
          text_n -= n;
        end
      end
      OP_PASTE: begin
        if (text_n + clip_n > DEPTH) r.st = ST_OVF;
        else begin
          for (int i = text_n - 1; i >= cur_n; i--) text_mem[i+clip_n] = text_mem[i];
          for (int i = 0; i < clip_n; i++) text_mem[cur_n+i] = clip_mem[i];
          text_n += clip_n;
          cur_n += clip_n;
        end
      end
      OP_READ: begin
        if (c.ridx < text_n) begin
          r.rvld = 1'b1;
          r.rch = text_mem[c.ridx];
        end
      end
      default: ;
    endcase
    r.cur = cur_n[POS_W-1:0];
    r.tlen = text_n[POS_W-1:0];
    r.clen = clip_n[POS_W-1:0];
    return r;
  endfunction

  function automatic edit_cmd_t mk_cmd(int op, int ch, int cnt, int ridx);
    edit_cmd_t c;
    c.op = op[OPCODE_W-1:0];
    c.ch = ch[CHAR_W-1:0];
    c.cnt = cnt[COUNT_W-1:0];
    c.ridx = ridx[RIDX_W-1:0];
    return c;
  endfunction

  // random command, weighted toward inserts so the text grows and edits reach depth
  function automatic edit_cmd_t rand_cmd();
    int w;
    int op;
    int cnt;
    w = $urandom_range(99);
    if (w < 35) op = OP_INSERT;
    else if (w < 47) op = OP_LEFT;
    else if (w < 57) op = OP_RIGHT;
    else if (w < 64) op = OP_CUT;
    else if (w < 71) op = OP_COPY;
    else if (w < 78) op = OP_PASTE;
    else if (w < 97) op = OP_READ;
    else op = 7;
    // mostly short spans keep cut, copy and paste fast
    cnt = ($urandom_range(9) == 0) ? $urandom_range(256, 0) : $urandom_range(12);
    if ($urandom_range(30) == 0) cnt = $urandom_range(511, 257);
    return mk_cmd(op, $urandom_range(255), cnt, $urandom_range(255));
  endfunction

  // driver: keeps valid and payload steady until the word is taken
  int send_gap = 0;
  always @(posedge clk) begin
    edit_cmd_t c;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        expected_results.push_back(apply_edit(pending_cmds.pop_front()));
        cmds_accepted++;
      end
      if (cmd_valid && !cmd_ready) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (idle_enable && $urandom_range(7) == 0) begin
        send_gap = $urandom_range(15);
        cmd_valid <= 1'b0;
      end else if ((cmd_valid && cmd_ready ? pending_cmds.size() : pending_cmds.size()) > 0) begin
        c = pending_cmds[0];
        cmd_valid <= 1'b1;
        opcode <= c.op;
        char_in <= c.ch;
        count <= c.cnt;
        read_index <= c.ridx;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // monitor: compares each result word with the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    edit_res_t e;
    if (!rst) begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, status %0d cursor %0d", $time, status,
                   cursor_pos);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (status !== e.st) begin
            $display("%0t: status exp %0d got %0d", $time, e.st, status); errors++;
          end
          if (cursor_pos !== e.cur) begin
            $display("%0t: cursor_pos exp %0d got %0d", $time, e.cur, cursor_pos); errors++;
          end
          if (text_size !== e.tlen) begin
            $display("%0t: text_size exp %0d got %0d", $time, e.tlen, text_size); errors++;
          end
          if (clip_len !== e.clen) begin
            $display("%0t: clip_len exp %0d got %0d", $time, e.clen, clip_len); errors++;
          end
          if (read_char !== e.rch) begin
            $display("%0t: read_char exp %0h got %0h", $time, e.rch, read_char); errors++;
          end
          if (read_valid !== e.rvld) begin
            $display("%0t: read_valid exp %0d got %0d", $time, e.rvld, read_valid); errors++;
          end
        end
      end
      // receiver stalls in bursts, or a long hold when asked
      if (hold_results) res_ready <= 1'b0;
      else if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(15);
        res_ready <= 1'b0;
      end else res_ready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    text_n = 0; cur_n = 0; clip_n = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: moves on empty text, reads and edits of nothing, then extremes
    pending_cmds.push_back(mk_cmd(OP_LEFT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_RIGHT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_READ, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_PASTE, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_CUT, 0, 256, 0));
    pending_cmds.push_back(mk_cmd(OP_INSERT, 8'hff, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_INSERT, 8'h00, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_INSERT, 8'ha5, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_RIGHT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_LEFT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_LEFT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_COPY, 0, 511, 0));
    pending_cmds.push_back(mk_cmd(OP_PASTE, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_READ, 0, 0, 255));
    pending_cmds.push_back(mk_cmd(OP_READ, 0, 0, 2));
    pending_cmds.push_back(mk_cmd(OP_CUT, 0, 1, 0));
    pending_cmds.push_back(mk_cmd(OP_COPY, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(7, 8'h5a, 9'h1ff, 8'haa));
    pending_cmds.push_back(mk_cmd(OP_LEFT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_LEFT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_LEFT, 0, 0, 0));
    // sender pauses until all results are in
    wait_drained();

    // long receiver hold while commands keep coming, so the input stalls
    hold_results = 1'b1;
    for (int i = 0; i < 20; i++) pending_cmds.push_back(rand_cmd());
    repeat (400) @(posedge clk);
    hold_results = 1'b0;
    wait_drained();

    // random body with idling on both sides
    for (int i = 0; i < 140; i++) begin
      pending_cmds.push_back(rand_cmd());
      if (pending_cmds.size() > 8) while (pending_cmds.size() > 2) @(posedge clk);
    end
    wait_drained();

    // last part with no idling: fill to capacity for overflow on insert and paste
    idle_enable = 1'b0;
    for (int i = 0; i < 260; i++) pending_cmds.push_back(mk_cmd(OP_INSERT, $urandom_range(255), 0, 0));
    pending_cmds.push_back(mk_cmd(OP_PASTE, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_READ, 0, 0, 255));
    pending_cmds.push_back(mk_cmd(OP_RIGHT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_CUT, 0, 256, 0));
    for (int i = 0; i < 3; i++) pending_cmds.push_back(mk_cmd(OP_LEFT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_CUT, 0, 256, 0));
    pending_cmds.push_back(mk_cmd(OP_PASTE, 0, 0, 0));
    wait_drained();
    repeat (600) @(posedge clk);

    $display("covered %0d commands and %0d results: moves, inserts, cut/copy/paste, reads",
             cmds_accepted, results_seen);
    $display("text reached capacity with overflow on insert and paste, long result stall");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/tbce_pkg.sv
hdl/tbce_ram.sv
hdl/tbce_ctrl.sv
hdl/tbce_dp.sv
hdl/text_buffer_cursor_editor_top.sv
hdl/tbce_checker.sv
tb/text_buffer_cursor_editor_top_test.sv
